// File: rtl/core/zeo_pkg.sv
// shared types and codes for the zip64 extra field offset extractor
`default_nettype none

package zeo_pkg;

  // walker phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_ZIP64  = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // record id of the zip64 extended information record
  localparam logic [15:0] ZIP64_ID = 16'd1;

  // size in bytes of one 64-bit value
  localparam logic [5:0] WORD_BYTES = 6'd8;

  // one byte request as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] skip_words;
    logic       last_byte;
  } req_t;

endpackage

`default_nettype wire

// File: rtl/core/zeo_in_reg.sv
// input register stage for byte requests
`default_nettype none

module zeo_in_reg import zeo_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic [1:0] skip_words,
  input  wire logic       last_byte,
  input  wire logic       advance,
  output logic            req_valid,
  output req_t            req
);

  // the register frees up when its request moves on
  assign in_ready = !req_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.data_byte  <= data_byte;
      req.skip_words <= skip_words;
      req.last_byte  <= last_byte;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/zeo_walker.sv
// record walker state and result register
`default_nettype none

module zeo_walker import zeo_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire req_t        req,
  output logic             advance,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      local_offset,
  output logic [1:0]       status
);

  // field state
  logic        mid_field;
  logic [1:0]  phase;
  logic [1:0]  header_count;
  logic [15:0] record_id;
  logic [15:0] body_left;
  logic [15:0] body_index;
  logic [1:0]  skip_latched;
  logic [63:0] value_accumulator;
  logic [1:0]  outcome;

  logic [1:0]  phase_next;
  logic [1:0]  header_count_next;
  logic [15:0] record_id_next;
  logic [15:0] body_left_next;
  logic [15:0] body_index_next;
  logic [1:0]  skip_latched_next;
  logic [63:0] value_accumulator_next;
  logic [1:0]  outcome_next;

  logic        take;
  logic [4:0]  start;
  logic [5:0]  limit;
  logic [15:0] hdr_left;
  logic [1:0]  st;

  // a request moves on unless a result is stuck in the output register
  assign advance = !out_valid || out_ready;
  assign take    = req_valid && advance;

  // byte step: first byte of a field starts from a clean state
  always_comb begin
    phase_next             = mid_field ? phase : PH_HEADER;
    header_count_next      = mid_field ? header_count : 2'd0;
    record_id_next         = mid_field ? record_id : 16'd0;
    body_left_next         = mid_field ? body_left : 16'd0;
    body_index_next        = mid_field ? body_index : 16'd0;
    skip_latched_next      = mid_field ? skip_latched : req.skip_words;
    value_accumulator_next = mid_field ? value_accumulator : 64'd0;
    outcome_next           = mid_field ? outcome : ST_MISSING;

    start    = {skip_latched_next, 3'b000};
    limit    = {1'b0, start} + WORD_BYTES;
    hdr_left = {req.data_byte, body_left_next[7:0]};

    case (phase_next)
      PH_HEADER: begin
        case (header_count_next)
          2'd0: record_id_next = {8'd0, req.data_byte};
          2'd1: record_id_next = {req.data_byte, record_id_next[7:0]};
          2'd2: body_left_next = {8'd0, req.data_byte};
          default: body_left_next = hdr_left;
        endcase
        header_count_next = header_count_next + 2'd1;
        // header complete: decide what the body is
        if (header_count == 2'd3 && mid_field) begin
          if (record_id_next == ZIP64_ID) begin
            if (hdr_left < {10'd0, limit}) begin
              outcome_next = ST_INVALID;
              phase_next   = PH_DONE;
            end else begin
              body_index_next        = 16'd0;
              value_accumulator_next = 64'd0;
              phase_next             = PH_ZIP64;
            end
          end else if (hdr_left != 16'd0) begin
            phase_next = PH_SKIP;
          end else begin
            phase_next = PH_HEADER;
          end
        end
      end
      PH_SKIP: begin
        body_left_next = body_left_next - 16'd1;
        if (body_left_next == 16'd0) begin
          phase_next = PH_HEADER;
        end
      end
      PH_ZIP64: begin
        // capture the offset bytes, little-endian
        if (body_index_next >= {11'd0, start} && body_index_next < {10'd0, limit}) begin
          value_accumulator_next[{body_index_next[2:0], 3'b000} +: 8] = req.data_byte;
        end
        body_index_next = body_index_next + 16'd1;
        body_left_next  = body_left_next - 16'd1;
        if (body_left_next == 16'd0) begin
          outcome_next = ST_FOUND;
          phase_next   = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    // final status of the field
    st = (phase_next == PH_ZIP64) ? ST_INVALID : outcome_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_field    <= 1'b0;
      phase        <= PH_HEADER;
      header_count <= 2'd0;
      outcome      <= ST_MISSING;
    end else if (take) begin
      mid_field    <= !req.last_byte;
      phase        <= phase_next;
      header_count <= header_count_next;
      outcome      <= outcome_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      record_id         <= record_id_next;
      body_left         <= body_left_next;
      body_index        <= body_index_next;
      skip_latched      <= skip_latched_next;
      value_accumulator <= value_accumulator_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && req.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && req.last_byte) begin
      status       <= st;
      local_offset <= (st == ST_FOUND) ? value_accumulator_next : 64'd0;
    end
  end

  // status is always one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_FOUND || status == ST_MISSING || status == ST_INVALID))
    else $error("bad status code");

  // offset is zero unless the record was found
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_FOUND) |-> local_offset == 64'd0)
    else $error("offset not cleared");

  // the last byte closes the field
  a_field_close: assert property (@(posedge clk) disable iff (rst)
    (take && req.last_byte) |=> (!mid_field && out_valid))
    else $error("field not closed");

  // a capture phase always has body bytes left
  a_body_left: assert property (@(posedge clk) disable iff (rst)
    (mid_field && phase == PH_ZIP64) |-> body_left != 16'd0)
    else $error("empty body in capture phase");

endmodule

`default_nettype wire

// File: rtl/core/zip64_extra_offset_extractor.sv
// top level of the zip64 extra field offset extractor
//
//  channel | signals                                    | handshake
//  --------+--------------------------------------------+-----------------------
//  input   | data_byte, skip_words, last_byte           | in_valid / in_ready
//  output  | local_offset, status                       | out_valid / out_ready
//
// one byte request per cycle while in_ready is high; once the last byte of a field is
// accepted, the walker updates from the input register into the result register,
// which raises out_valid; an unaccepted result ahead of it holds the byte back.
// rst is synchronous and clears the walker to the start of a field.
// in_ready drops only while a result sits unaccepted and the input register
// is full; the input register and the result register part the two sides.
`default_nettype none

module zip64_extra_offset_extractor import zeo_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic [1:0]  skip_words,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      local_offset,
  output logic [1:0]       status
);

  logic advance;
  logic req_valid;
  req_t req;

  // input register
  zeo_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .skip_words (skip_words),
    .last_byte  (last_byte),
    .advance    (advance),
    .req_valid  (req_valid),
    .req        (req)
  );

  // record walker and result register
  zeo_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req          (req),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .local_offset (local_offset),
    .status       (status)
  );

endmodule

`default_nettype wire

// File: tb/zeo_offset_checker.sv
// checker for the zip64 extra field offset extractor: field walker and result compare
`timescale 1ns / 100ps

module zeo_offset_checker import zeo_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic [1:0]  skip_words,
  input  wire logic        last_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [63:0] local_offset,
  input  wire logic [1:0]  status,
  output int               fail_count,
  output int               open_results
);

  typedef struct packed {
    logic [63:0] offset;
    logic [1:0]  code;
  } field_result_t;

  // results owed by the block, oldest first
  field_result_t pending_results[$];

  // walker state of the field in flight
  logic [1:0]  walk_phase;
  logic [1:0]  hdr_cnt;
  logic [15:0] rec_id;
  logic [15:0] body_left;
  logic [15:0] body_idx;
  logic [1:0]  skip_lat;
  logic [63:0] offset_acc;
  logic [1:0]  verdict;
  bit          in_field;

  initial begin
    fail_count   = 0;
    open_results = 0;
  end

  task automatic clear_walker();
    walk_phase = PH_HEADER;
    hdr_cnt    = 2'd0;
    rec_id     = '0;
    body_left  = '0;
    body_idx   = '0;
    skip_lat   = 2'd0;
    offset_acc = '0;
    verdict    = ST_MISSING;
    in_field   = 1'b0;
  endtask

  // advance the walker by one accepted byte request
  task automatic walk_byte(input logic [7:0] b, input logic [1:0] s, input logic l);
    int unsigned   first_byte;
    int unsigned   k;
    field_result_t res;
    if (!in_field) begin
      clear_walker();
      skip_lat = s;
      in_field = 1'b1;
    end
    first_byte = WORD_BYTES * skip_lat;
    case (walk_phase)
      PH_HEADER: begin
        // little-endian id, then little-endian body length
        case (hdr_cnt)
          2'd0: rec_id = {8'h00, b};
          2'd1: rec_id[15:8] = b;
          2'd2: body_left = {8'h00, b};
          default: body_left[15:8] = b;
        endcase
        if (hdr_cnt == 2'd3) begin
          hdr_cnt = 2'd0;
          if (rec_id == ZIP64_ID) begin
            // the record must hold the skipped words and the offset
            if (body_left < first_byte + WORD_BYTES) begin
              verdict    = ST_INVALID;
              walk_phase = PH_DONE;
            end else begin
              body_idx   = '0;
              offset_acc = '0;
              walk_phase = PH_ZIP64;
            end
          end else if (body_left != 16'd0) begin
            walk_phase = PH_SKIP;
          end else begin
            walk_phase = PH_HEADER;
          end
        end else begin
          hdr_cnt++;
        end
      end
      PH_SKIP: begin
        body_left--;
        if (body_left == 16'd0) walk_phase = PH_HEADER;
      end
      PH_ZIP64: begin
        // capture the offset word behind the skipped lengths
        if (body_idx >= first_byte && body_idx < first_byte + WORD_BYTES) begin
          k = body_idx - first_byte;
          offset_acc[8*k +: 8] = b;
        end
        body_idx++;
        body_left--;
        if (body_left == 16'd0) begin
          verdict    = ST_FOUND;
          walk_phase = PH_DONE;
        end
      end
      default: ;
    endcase
    // the last byte closes the field with one result
    if (l) begin
      res.code   = (walk_phase == PH_ZIP64) ? ST_INVALID : verdict;
      res.offset = (res.code == ST_FOUND) ? offset_acc : 64'd0;
      pending_results.push_back(res);
      clear_walker();
    end
  endtask

  // watch both channels at each rising edge
  always @(posedge clk) begin : watch
    field_result_t want;
    if (rst) begin
      clear_walker();
    end else begin
      if (in_valid && in_ready) walk_byte(data_byte, skip_words, last_byte);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual offset %h status %0d",
                   $time, local_offset, status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (local_offset !== want.offset || status !== want.code) begin
            if (local_offset !== want.offset)
              $display("%0t: local_offset mismatch: expected %h, actual %h",
                       $time, want.offset, local_offset);
            if (status !== want.code)
              $display("%0t: status mismatch: expected %0d, actual %0d",
                       $time, want.code, status);
            fail_count++;
          end
        end
      end
    end
    open_results = pending_results.size();
  end

endmodule

// File: tb/zip64_extra_offset_extractor_tb.sv
// testbench top for the zip64 extra field offset extractor: stimulus and verdict
`timescale 1ns / 100ps

module zip64_extra_offset_extractor_tb;
  import zeo_pkg::*;

  logic        clk;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic [7:0]  data_byte  = 8'd0;
  logic [1:0]  skip_words = 2'd0;
  logic        last_byte  = 1'b0;
  logic        out_ready  = 1'b0;
  wire logic        in_ready;
  wire logic        out_valid;
  wire logic [63:0] local_offset;
  wire logic [1:0]  status;
  int fail_count;
  int open_results;

  // field being built, and its skip count
  logic [7:0] field_bytes[$];
  logic [1:0] field_skip;
  bit calm    = 1'b0;
  bit gaps_on = 1'b1;
  int bytes_sent  = 0;
  int fields_sent = 0;
  int stall_left  = 0;

  zip64_extra_offset_extractor dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .skip_words   (skip_words),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .local_offset (local_offset),
    .status       (status)
  );

  zeo_offset_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .skip_words   (skip_words),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .local_offset (local_offset),
    .status       (status),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stall bursts, always ready once calm
  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [15:0] other_id();
    logic [15:0] id;
    id = 16'($urandom);
    if (id == ZIP64_ID) id = 16'hffff;
    return id;
  endfunction

  task automatic push_header(input logic [15:0] id, input logic [15:0] len);
    field_bytes.push_back(id[7:0]);
    field_bytes.push_back(id[15:8]);
    field_bytes.push_back(len[7:0]);
    field_bytes.push_back(len[15:8]);
  endtask

  task automatic push_noise(input int n);
    repeat (n) field_bytes.push_back(8'($urandom));
  endtask

  // present the built field one byte request at a time
  task automatic send_field();
    for (int i = 0; i < field_bytes.size(); i++) begin
      if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      in_valid   <= 1'b1;
      data_byte  <= field_bytes[i];
      skip_words <= (i == 0) ? field_skip : 2'($urandom_range(0, 3));
      last_byte  <= (i == field_bytes.size() - 1);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
      bytes_sent++;
    end
    field_bytes.delete();
    fields_sent++;
  endtask

  // hold off until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (open_results != 0) @(negedge clk);
  endtask

  // mostly well-formed fields with random content, some noise
  task automatic build_random_field();
    int          kind;
    int          need;
    logic [15:0] len;
    field_skip = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    need = WORD_BYTES * field_skip + WORD_BYTES;
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      push_noise($urandom_range(1, 10));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        len = 16'($urandom_range(0, 6));
        push_header(other_id(), len);
        push_noise(int'(len));
      end
      if (kind < 13) begin
        // good record, trailing bytes ignored
        len = 16'(need + $urandom_range(0, 5));
        push_header(ZIP64_ID, len);
        push_noise(int'(len));
        push_noise($urandom_range(0, 3));
      end else if (kind < 15) begin
        // record too short for the skip count
        len = 16'($urandom_range(0, need - 1));
        push_header(ZIP64_ID, len);
        push_noise($urandom_range(0, 4));
      end else if (kind < 17) begin
        // record running past the field end
        len = 16'(need + $urandom_range(0, 4));
        push_header(ZIP64_ID, len);
        push_noise($urandom_range(0, len - 1));
      end else if (kind == 17) begin
        // header cut off
        push_noise($urandom_range(1, 3));
      end else if (kind == 18) begin
        // other record overrun
        len = 16'($urandom_range(1, 12));
        push_header(other_id(), len);
        push_noise($urandom_range(0, len - 1));
      end
    end
    if (field_bytes.size() == 0) push_header(other_id(), 16'd0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single byte: header cut off
    field_skip = 2'd0;
    field_bytes.push_back(8'hff);
    send_field();
    // all-ones offset with no skip
    field_skip = 2'd0;
    push_header(ZIP64_ID, 16'd8);
    repeat (8) field_bytes.push_back(8'hff);
    send_field();
    // zero offset behind two all-ones lengths
    field_skip = 2'd2;
    push_header(ZIP64_ID, 16'd24);
    repeat (16) field_bytes.push_back(8'hff);
    repeat (8) field_bytes.push_back(8'h00);
    send_field();
    // skip of three with a body one byte short
    field_skip = 2'd3;
    push_header(ZIP64_ID, 16'd31);
    field_bytes.push_back(8'h5a);
    send_field();
    // zip64 record past the field end
    field_skip = 2'd0;
    push_header(ZIP64_ID, 16'd8);
    push_noise(3);
    send_field();
    // other record ending exactly at the field end
    field_skip = 2'd1;
    push_header(16'hffff, 16'd2);
    push_noise(2);
    send_field();
    // empty other record, then a found offset with bytes after it
    field_skip = 2'd0;
    push_header(16'h0000, 16'd0);
    push_header(ZIP64_ID, 16'd9);
    push_noise(11);
    send_field();
    // longest other record cut by the field end
    field_skip = 2'd0;
    push_header(16'h1234, 16'hffff);
    push_noise(2);
    send_field();
    drain();

    // random fields, quiet toward the end
    while (bytes_sent < 600 || fields_sent < 20) begin
      calm    = (bytes_sent >= 520);
      gaps_on = ($urandom_range(0, 3) != 0);
      build_random_field();
      send_field();
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
    repeat (8) @(negedge clk);

    if (fail_count == 0 && open_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
